FILE: rtl/astar_grid_cell_relaxation_defines.svh
// Assertion macros for the A* cell relaxation block.
`ifndef ASTAR_GRID_CELL_RELAXATION_DEFINES_SVH
`define ASTAR_GRID_CELL_RELAXATION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ASTAR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASTAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/astar_pkg.sv
// Shared types and constants of the A* cell relaxation block.
package astar_pkg;

    localparam int IDX_W      = 12;
    localparam int COLS_W     = 13;
    localparam int F_W        = 17;
    localparam int G_W        = 16;
    localparam int H_W        = 16;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int DIV_LANES  = 2;
    localparam int DIV_CNT_W  = $clog2(IDX_W + 1);

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(IDX_W);

    localparam logic [STEP_W-1:0] STEP_STRAIGHT = 4'd10;
    localparam logic [STEP_W-1:0] STEP_DIAGONAL = 4'd14;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_RELAX = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_CELL    = 1'b1;

    localparam logic [COLS_W-1:0] COLS_RESET = 13'd64;
    localparam logic [IDX_W-1:0]  GOAL_RESET = 12'd0;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] cell_index;
        logic [IDX_W-1:0] parent_index;
    } request_t;

    typedef struct packed {
        logic             updated;
        logic [F_W-1:0]   f_cost;
        logic [G_W-1:0]   g_cost;
        logic [H_W-1:0]   h_cost;
        logic [IDX_W-1:0] best_parent;
    } result_t;

    typedef struct packed {
        logic             has_parent;
        logic [IDX_W-1:0] parent;
        logic [F_W-1:0]   f;
        logic [G_W-1:0]   g;
        logic [H_W-1:0]   h;
    } entry_t;

    typedef struct packed {
        logic load;
        logic rd_par;
        logic rd_cell;
        logic cap_dist;
        logic cap_heu;
        logic cap_fsum;
        logic finish;
        logic clr_wr;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_done;
    } status_t;

endpackage

FILE: rtl/astar_grid_cell_relaxation.sv
// Top level of the A* cell relaxation block.
// An item is taken when start is high and busy is low. Its result appears on result
// with done high for exactly one cycle once the table write step is done, and the
// receiver cannot stall it. busy stays high from the taking edge until the result
// cycle, so a new item cannot be taken before the last one's result. The steps are the
// taking edge, the divider that turns the cell and goal indexes into column and row (the
// two table reads overlap it), a wait state to see the divider finish, then the octile
// distance, heuristic, F sum and table write steps. After reset the block first zeroes
// the cell table, one entry per cycle over all MAX_CELLS entries, with busy high.
// Configuration writes (cfg_ready is always high) are taken at any time and take
// effect at once, so write them only while no item is in progress.
module astar_grid_cell_relaxation #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  astar_pkg::request_t              request,
    output logic                             busy,
    output logic                             done,
    output astar_pkg::result_t               result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [astar_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [astar_pkg::CFG_DATA_W-1:0] cfg_data
);

    astar_pkg::cmd_t    cmd;
    astar_pkg::status_t status;

    assign cfg_ready = 1'b1;

    astar_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    astar_dp #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (request),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

FILE: rtl/astar_div.sv
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
module astar_div (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   start,
    input  logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W-1:0]  dividend,
    input  logic [astar_pkg::COLS_W-1:0]                           divisor,
    output logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W-1:0]  quotient,
    output logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W-1:0]  remainder,
    output logic                                                   done
);

    logic                                                  running_reg;
    logic [astar_pkg::DIV_CNT_W-1:0]                       cnt_reg;
    logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W-1:0] dvd_reg;
    logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W-1:0] rem_reg;
    logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W-1:0] dvd_next;
    logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W-1:0] rem_next;
    logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W:0]   trial;
    logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W:0]   diff;
    logic [astar_pkg::DIV_LANES-1:0]                       ge;

    always_comb
    begin
        for (int i = 0; i < astar_pkg::DIV_LANES; i++)
        begin
            trial[i]    = {rem_reg[i], dvd_reg[i][astar_pkg::IDX_W-1]};
            ge[i]       = trial[i] >= divisor;
            diff[i]     = trial[i] - divisor;
            rem_next[i] = ge[i] ? diff[i][astar_pkg::IDX_W-1:0]
                                : trial[i][astar_pkg::IDX_W-1:0];
            dvd_next[i] = {dvd_reg[i][astar_pkg::IDX_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else if (start)
        begin
            running_reg <= 1'b1;
            cnt_reg     <= astar_pkg::DIV_STEPS;
        end
        else if (running_reg)
        begin
            cnt_reg <= cnt_reg - astar_pkg::DIV_CNT_W'(1);
            if (cnt_reg == astar_pkg::DIV_CNT_W'(1))
            begin
                running_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (running_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = dvd_reg;
    assign remainder = rem_reg;
    assign done      = !running_reg;

endmodule

FILE: rtl/astar_dp.sv
// Datapath: configuration, cell table, cost arithmetic and result register.
module astar_dp #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [astar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [astar_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  astar_pkg::request_t                 request,
    input  astar_pkg::cmd_t                     cmd,
    output astar_pkg::status_t                  status,
    output astar_pkg::result_t                  result
);

    localparam int AW    = $clog2(MAX_CELLS);
    localparam int EXT_W = ((AW >= astar_pkg::IDX_W) ? AW : astar_pkg::IDX_W) + 1;
    localparam int NEAR_W = astar_pkg::COLS_W + 1;

    logic [astar_pkg::COLS_W-1:0] cols_reg;
    logic [astar_pkg::IDX_W-1:0]  goal_reg;
    logic [astar_pkg::COLS_W-1:0] cols;

    astar_pkg::request_t req_reg;
    astar_pkg::entry_t   mem [MAX_CELLS];
    astar_pkg::entry_t   rd_reg;
    astar_pkg::entry_t   wr_data;
    astar_pkg::result_t  result_reg;
    astar_pkg::result_t  result_next;

    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] par_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          rd_en;

    logic [EXT_W-1:0] cell_ext;
    logic [EXT_W-1:0] par_ext;
    logic             cell_oob;
    logic             par_oob;

    logic [NEAR_W-1:0] near_c;
    logic [NEAR_W-1:0] near_x;
    logic [NEAR_W-1:0] near_p;
    logic              near;

    logic [astar_pkg::STEP_W-1:0] step_reg;
    logic [astar_pkg::G_W:0]      g_sum;
    logic [astar_pkg::G_W-1:0]    g_new_reg;
    logic [astar_pkg::IDX_W-1:0]  dx_reg;
    logic [astar_pkg::IDX_W-1:0]  dy_reg;
    logic [astar_pkg::IDX_W-1:0]  dx_next;
    logic [astar_pkg::IDX_W-1:0]  dy_next;
    logic [astar_pkg::IDX_W-1:0]  lo;
    logic [astar_pkg::IDX_W-1:0]  hi;
    logic [astar_pkg::H_W-1:0]    h_reg;
    logic [astar_pkg::H_W-1:0]    h_next;
    logic [astar_pkg::F_W-1:0]    f_reg;
    logic                         take_new;
    logic                         do_clear;

    logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W-1:0] div_in;
    logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W-1:0] quo;
    logic [astar_pkg::DIV_LANES-1:0][astar_pkg::IDX_W-1:0] rem;
    logic                                                  div_done;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= astar_pkg::COLS_RESET;
            goal_reg <= astar_pkg::GOAL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                astar_pkg::CFG_GRID_COLUMNS: cols_reg <= cfg_data[astar_pkg::COLS_W-1:0];
                astar_pkg::CFG_GOAL_CELL:    goal_reg <= cfg_data[astar_pkg::IDX_W-1:0];
                default:                     cols_reg <= cols_reg;
            endcase
        end
    end

    assign cols = (cols_reg == '0) ? astar_pkg::COLS_W'(1) : cols_reg;

    assign div_in[0] = request.cell_index;
    assign div_in[1] = goal_reg;

    astar_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.load),
        .dividend  (div_in),
        .divisor   (cols),
        .quotient  (quo),
        .remainder (rem),
        .done      (div_done)
    );

    always_comb
    begin
        cell_ext  = EXT_W'(req_reg.cell_index);
        par_ext   = EXT_W'(req_reg.parent_index);
        cell_oob  = cell_ext >= EXT_W'(MAX_CELLS);
        par_oob   = par_ext >= EXT_W'(MAX_CELLS);
        cell_addr = cell_ext[AW-1:0];
        par_addr  = par_ext[AW-1:0];

        near_c = NEAR_W'(cols);
        near_x = NEAR_W'(req_reg.cell_index);
        near_p = NEAR_W'(req_reg.parent_index);
        near   = ((near_x != '0) && (near_p == near_x - NEAR_W'(1)))
              || (near_p == near_x + NEAR_W'(1))
              || ((near_x >= near_c) && (near_p == near_x - near_c))
              || (near_p == near_x + near_c);

        g_sum = (astar_pkg::G_W + 1)'(step_reg) + (astar_pkg::G_W + 1)'(rd_reg.g);

        dx_next = (rem[0] >= rem[1]) ? rem[0] - rem[1] : rem[1] - rem[0];
        dy_next = (quo[0] >= quo[1]) ? quo[0] - quo[1] : quo[1] - quo[0];
        lo      = (dx_reg < dy_reg) ? dx_reg : dy_reg;
        hi      = (dx_reg < dy_reg) ? dy_reg : dx_reg;
        h_next  = (astar_pkg::H_W'(hi) << 3) + (astar_pkg::H_W'(hi) << 1)
                + (astar_pkg::H_W'(lo) << 2);

        do_clear = !cell_oob && (req_reg.operation == astar_pkg::OP_CLEAR);
        take_new = !cell_oob && (req_reg.operation == astar_pkg::OP_RELAX) && !par_oob
                && (!rd_reg.has_parent || (f_reg < rd_reg.f));

        wr_en   = cmd.clr_wr || (cmd.finish && (do_clear || take_new));
        wr_addr = cmd.clr_wr ? clr_addr_reg : cell_addr;
        rd_en   = cmd.rd_par || cmd.rd_cell;
        rd_addr = cmd.rd_par ? par_addr : cell_addr;

        if (cmd.clr_wr)
        begin
            wr_data = '0;
        end
        else if (do_clear)
        begin
            wr_data            = rd_reg;
            wr_data.has_parent = 1'b0;
            wr_data.g          = '0;
        end
        else
        begin
            wr_data.has_parent = 1'b1;
            wr_data.parent     = req_reg.parent_index;
            wr_data.f          = f_reg;
            wr_data.g          = g_new_reg;
            wr_data.h          = h_reg;
        end

        if (cell_oob)
        begin
            result_next = '0;
        end
        else if (do_clear || take_new)
        begin
            result_next.updated     = take_new;
            result_next.f_cost      = wr_data.f;
            result_next.g_cost      = wr_data.g;
            result_next.h_cost      = wr_data.h;
            result_next.best_parent = wr_data.has_parent ? wr_data.parent : '0;
        end
        else
        begin
            result_next.updated     = 1'b0;
            result_next.f_cost      = rd_reg.f;
            result_next.g_cost      = rd_reg.g;
            result_next.h_cost      = rd_reg.h;
            result_next.best_parent = rd_reg.has_parent ? rd_reg.parent : '0;
        end
    end

    // clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.rd_par)
        begin
            step_reg <= near ? astar_pkg::STEP_STRAIGHT : astar_pkg::STEP_DIAGONAL;
        end
        if (cmd.rd_cell)
        begin
            g_new_reg <= g_sum[astar_pkg::G_W] ? '1 : g_sum[astar_pkg::G_W-1:0];
        end
        if (cmd.cap_dist)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (cmd.cap_heu)
        begin
            h_reg <= h_next;
        end
        if (cmd.cap_fsum)
        begin
            f_reg <= astar_pkg::F_W'(g_new_reg) + astar_pkg::F_W'(h_reg);
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign status.clr_last = clr_addr_reg == AW'(MAX_CELLS - 1);
    assign status.div_done = div_done;
    assign result          = result_reg;

endmodule

FILE: rtl/astar_ctrl.sv
// Controller: sequences the clearing pass and the steps of each item.
module astar_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  astar_pkg::status_t status,
    output astar_pkg::cmd_t    cmd,
    output logic               busy,
    output logic               done
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_PAR,
        S_RD_CELL,
        S_WAIT,
        S_DIST,
        S_HEU,
        S_FSUM,
        S_UPD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD_PAR;
                end
            end
            S_RD_PAR:
            begin
                cmd.rd_par = 1'b1;
                state_next = S_RD_CELL;
            end
            S_RD_CELL:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_DIST;
                end
            end
            S_DIST:
            begin
                cmd.cap_dist = 1'b1;
                state_next   = S_HEU;
            end
            S_HEU:
            begin
                cmd.cap_heu = 1'b1;
                state_next  = S_FSUM;
            end
            S_FSUM:
            begin
                cmd.cap_fsum = 1'b1;
                state_next   = S_UPD;
            end
            S_UPD:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != S_IDLE;
            done_reg  <= state_reg == S_UPD;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: rtl/astar_chk.sv
// Port-level checker for the A* cell relaxation block, with its bind.
`include "astar_grid_cell_relaxation_defines.svh"

module astar_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input astar_pkg::result_t result
);

    `ASTAR_ASSERT_NEXT(a_take_sets_busy, clk, rst_n, start && !busy, busy, "item taken but busy low")
    `ASTAR_ASSERT_SAME(a_done_after_busy, clk, rst_n, done, !busy && $past(busy), "result without work")
    `ASTAR_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe longer than one cycle")
    `ASTAR_ASSERT_SAME(a_updated_sum, clk, rst_n, done && result.updated, result.f_cost == astar_pkg::F_W'(result.g_cost) + astar_pkg::F_W'(result.h_cost), "F differs from G plus H")

endmodule

bind astar_grid_cell_relaxation astar_chk u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
